// ===== design/gef_pkg.sv =====
// Package for the escape framer: byte constants, the position state type and
// the command word passed from the classifier to the beat sequencer.
// No dependencies.
package gef_pkg;

    localparam logic [7:0] LF_BYTE   = 8'd10;
    localparam logic [7:0] CR_BYTE   = 8'd13;
    localparam logic [7:0] ESC_BYTE  = 8'd27;
    localparam logic [7:0] PLUS_BYTE = 8'd43;

    // Position of the next byte within the message.
    typedef enum logic [2:0] {
        POS_FIRST  = 3'b001,
        POS_SECOND = 3'b010,
        POS_LATER  = 3'b100
    } t_pos;

    // Output beat slots of one command, in emission order.
    localparam int STEP_COUNT    = 5;
    localparam int STEP_PLUS_ESC = 0;
    localparam int STEP_PLUS     = 1;
    localparam int STEP_DATA_ESC = 2;
    localparam int STEP_DATA     = 3;
    localparam int STEP_LF       = 4;

    typedef logic [STEP_COUNT-1:0] t_step_mask;

    // One classified input byte and the beats it expands to.
    typedef struct packed {
        logic [7:0] data;
        logic       emit_plus;  // a held leading plus goes out first
        logic       plus_esc;   // that plus gets an ESC in front
        logic       data_esc;   // the data byte gets an ESC in front
        logic       lf;         // a terminating line feed follows
    } t_cmd;

    function automatic logic needs_escape(input logic [7:0] b);
        return (b == LF_BYTE) || (b == CR_BYTE) || (b == ESC_BYTE) || (b == PLUS_BYTE);
    endfunction

endpackage

// ===== design/gef_front.sv =====
// Front end of the escape framer: tracks the message position and mode and
// turns each accepted byte into a command word. Depends on gef_pkg.
module gef_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_byte,
    output logic          o_push,
    output gef_pkg::t_cmd o_cmd,
    input  logic          i_queue_ready
);
    import gef_pkg::*;

    t_pos r_pos, n_pos;
    logic r_mode, n_mode;
    logic accept;
    logic hold;

    assign o_ready = i_queue_ready;
    assign accept  = i_valid && i_queue_ready;

    always_comb begin
        o_cmd.data      = i_data_byte;
        o_cmd.emit_plus = 1'b0;
        o_cmd.plus_esc  = 1'b0;
        o_cmd.data_esc  = needs_escape(i_data_byte);
        o_cmd.lf        = i_last_byte;
        hold            = 1'b0;
        n_mode          = r_mode;
        unique case (r_pos)
            POS_FIRST: begin
                // A leading plus waits for the next byte to pick the mode.
                hold   = (i_data_byte == PLUS_BYTE) && !i_last_byte;
                n_mode = 1'b0;
            end
            POS_SECOND: begin
                o_cmd.emit_plus = 1'b1;
                if (i_data_byte == PLUS_BYTE) begin
                    n_mode         = 1'b1;
                    o_cmd.data_esc = 1'b0;
                end else begin
                    n_mode         = 1'b0;
                    o_cmd.plus_esc = 1'b1;
                end
            end
            POS_LATER: begin
                o_cmd.data_esc = !r_mode && needs_escape(i_data_byte);
            end
            default: begin
                o_cmd.data_esc = !r_mode && needs_escape(i_data_byte);
            end
        endcase

        if (hold) begin
            n_pos = POS_SECOND;
        end else if (i_last_byte) begin
            n_pos  = POS_FIRST;
            n_mode = 1'b0;
        end else begin
            n_pos = POS_LATER;
        end
    end

    assign o_push = accept && !hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_FIRST;
            r_mode <= 1'b0;
        end else if (accept) begin
            r_pos  <= n_pos;
            r_mode <= n_mode;
        end
    end

    // A held plus never leaves a second-position byte without the plus in front.
    a_second_emits_plus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && r_pos == POS_SECOND) |-> o_cmd.emit_plus)
        else $error("second byte pushed without its held plus");

endmodule

// ===== design/gef_queue.sv =====
// Short command queue between the classifier and the beat sequencer, built
// from registers. Depends on gef_pkg.
module gef_queue #(
    parameter int P_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gef_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output gef_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import gef_pkg::*;

    localparam int PtrW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CntW = $clog2(P_DEPTH + 1);

    t_cmd            r_mem [P_DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push, do_pop;

    assign o_ready = (r_count != CntW'(P_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    assign n_wr_ptr = (r_wr_ptr == PtrW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PtrW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(P_DEPTH))
        else $error("queue count beyond depth");

    a_pointers_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with mismatched pointers");

endmodule

// ===== design/gef_back.sv =====
// Back end of the escape framer: expands the head command into its output
// beats, one beat per cycle while i_ready is high, and releases the command
// on its final beat. Depends on gef_pkg.
module gef_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  gef_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_out_last
);
    import gef_pkg::*;

    t_step_mask r_done, n_done;
    t_step_mask enabled, pending, cur;
    logic       final_beat, beat;

    always_comb begin
        enabled                = '0;
        enabled[STEP_PLUS_ESC] = i_cmd.emit_plus && i_cmd.plus_esc;
        enabled[STEP_PLUS]     = i_cmd.emit_plus;
        enabled[STEP_DATA_ESC] = i_cmd.data_esc;
        enabled[STEP_DATA]     = 1'b1;
        enabled[STEP_LF]       = i_cmd.lf;
    end

    // The lowest pending slot is the beat on the port now.
    assign pending    = enabled & ~r_done;
    assign cur        = pending & (~pending + 1'b1);
    assign final_beat = ((pending & ~cur) == '0);
    assign o_valid    = i_cmd_valid;
    assign beat       = o_valid && i_ready;
    assign o_pop      = beat && final_beat;

    always_comb begin
        o_out_last = 1'b0;
        if (cur[STEP_PLUS_ESC] || cur[STEP_DATA_ESC]) begin
            o_out_byte = ESC_BYTE;
        end else if (cur[STEP_PLUS]) begin
            o_out_byte = PLUS_BYTE;
        end else if (cur[STEP_LF]) begin
            o_out_byte = LF_BYTE;
            o_out_last = 1'b1;
        end else begin
            o_out_byte = i_cmd.data;
        end
    end

    assign n_done = final_beat ? '0 : (r_done | cur);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
        end else if (beat) begin
            r_done <= n_done;
        end
    end

    a_beat_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot(cur))
        else $error("valid command with no beat left");

    a_last_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_last) |-> final_beat)
        else $error("line feed before the end of a command");

endmodule

// ===== design/gpib_escape_framer.sv =====
// Top level of the escape framer: classifier, command queue, beat sequencer.
// Depends on gef_pkg, gef_front, gef_queue and gef_back.
//
// Frames message bytes for an adapter link. A message starting with two plus
// signs passes through unchanged; any other message has LF, CR, ESC and plus
// bytes preceded by ESC. Every message ends with a line feed marked by
// o_out_last. Each input byte is accepted while the queue has room and yields
// zero to five output beats at one beat per cycle while the output is ready,
// so the sustained rate is set by the output sequencer. A queue of
// P_QUEUE_DEPTH commands lets input keep flowing while output stalls.
module gpib_escape_framer #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);
    import gef_pkg::*;

    t_cmd front_cmd, head_cmd;
    logic push, queue_ready, head_valid, pop;

    gef_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_push        (push),
        .o_cmd         (front_cmd),
        .i_queue_ready (queue_ready)
    );

    gef_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (queue_ready),
        .o_valid (head_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    gef_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

endmodule
